@@ design/msb_pkg.sv @@
`timescale 1ns / 1ps
// msb_pkg: shared types and pattern tables for the masked sequence blanker
// used by msb_match, msb_window and masked_sequence_blanker; no dependencies
package msb_pkg;

  typedef logic [31:0] word_t;

  // longest pattern and width of the pending zero counter
  localparam int unsigned PAT_MAX = 27;
  localparam int unsigned ZRUN_W  = 5;
  localparam int unsigned NUM_SETS = 2;

  // pattern set codes
  localparam logic SET_LONG  = 1'b0;
  localparam logic SET_SHORT = 1'b1;

  localparam int unsigned PAT_LEN [NUM_SETS] = '{27, 12};

  // unused tail entries of the short set carry a zero mask
  localparam word_t PAT_CODE [NUM_SETS][PAT_MAX] = '{
    '{32'h3c041fc0, 32'h348407fc, 32'h0c000000, 32'h27a50034, 32'h10400007, 32'h00000000,
      32'h3c041fc0, 32'h348407fc, 32'h0c000000, 32'h27a50034, 32'h1440fffb, 32'h00000000,
      32'h8fa50034, 32'h3c041fc0, 32'h348407fc, 32'h34af0008, 32'h0c000000, 32'h01e02825,
      32'h10400009, 32'h00000000, 32'h8fa50034, 32'h3c041fc0, 32'h348407fc, 32'h34b80008,
      32'h0c000000, 32'h03002825, 32'h1440fff9},
    '{32'h3c041fc0, 32'h348407fc, 32'h0c000000, 32'h27a50010, 32'h1440fffc, 32'h3c041fc0,
      32'h8fa50010, 32'h3c041fc0, 32'h348407fc, 32'h0c000000, 32'h34a50008, 32'h1440fffa,
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0}
  };

  // first word of each set has a full mask, so it must match exactly
  localparam word_t PAT_MASK [NUM_SETS][PAT_MAX] = '{
    '{32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffe7, 32'hffffffff, 32'hffffffff,
      32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffe7, 32'hffffffff, 32'hffffffff,
      32'hffffffe7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffff,
      32'hffffffff, 32'hffffffff, 32'hffffffe7, 32'hffffffff, 32'hffffffff, 32'hffffffff,
      32'hfc000000, 32'hffffffff, 32'hffffffff},
    '{32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffff, 32'hffffffff, 32'hffffffff,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffff, 32'hffffffff,
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0}
  };

  // window control from the sequencer
  typedef struct packed {
    logic push;       // append the staged word at the fill position
    logic shift_one;  // drop the oldest word
    logic shift_pat;  // drop a whole matched chunk
    logic sel;        // active pattern set
  } win_ctrl_t;

endpackage

@@ design/msb_match.sv @@
`timescale 1ns / 1ps
// msb_match: parallel masked compare of the window head against the active pattern
// depends on msb_pkg
module msb_match #(
  parameter int unsigned WINDOW_DEPTH = 27
) (
  input  logic            sel_i,
  input  msb_pkg::word_t  win_i [WINDOW_DEPTH],
  output logic            match_o
);

  logic [msb_pkg::PAT_MAX-1:0] hit_long, hit_short;
  logic [msb_pkg::PAT_MAX-1:0] use_long, use_short;

  // per-position compare; positions past the window never hit
  for (genvar i = 0; i < msb_pkg::PAT_MAX; i++) begin : g_pos
    assign use_long[i]  = (i < msb_pkg::PAT_LEN[msb_pkg::SET_LONG]);
    assign use_short[i] = (i < msb_pkg::PAT_LEN[msb_pkg::SET_SHORT]);
    if (i < WINDOW_DEPTH) begin : g_in
      assign hit_long[i] = ((win_i[i] ^ msb_pkg::PAT_CODE[msb_pkg::SET_LONG][i])
                            & msb_pkg::PAT_MASK[msb_pkg::SET_LONG][i]) == '0;
      assign hit_short[i] = ((win_i[i] ^ msb_pkg::PAT_CODE[msb_pkg::SET_SHORT][i])
                             & msb_pkg::PAT_MASK[msb_pkg::SET_SHORT][i]) == '0;
    end else begin : g_out
      assign hit_long[i]  = 1'b0;
      assign hit_short[i] = 1'b0;
    end
  end

  // a pattern longer than the window can never match
  assign match_o = (sel_i == msb_pkg::SET_SHORT) ? &(hit_short | ~use_short)
                                                 : &(hit_long | ~use_long);

endmodule

@@ design/msb_window.sv @@
`timescale 1ns / 1ps
// msb_window: delay window of pending words with insert and chunk/word drop
// depends on msb_pkg
module msb_window #(
  parameter int unsigned WINDOW_DEPTH = 27,
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic               clk_i,
  input  msb_pkg::win_ctrl_t ctrl_i,
  input  logic [FILL_W-1:0]  fill_i,
  input  msb_pkg::word_t     word_i,
  output msb_pkg::word_t     vwin_o [WINDOW_DEPTH]
);

  localparam int unsigned LEN_LONG  = msb_pkg::PAT_LEN[msb_pkg::SET_LONG];
  localparam int unsigned LEN_SHORT = msb_pkg::PAT_LEN[msb_pkg::SET_SHORT];

  msb_pkg::word_t win_q [WINDOW_DEPTH];
  msb_pkg::word_t win_d [WINDOW_DEPTH];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_ent
    msb_pkg::word_t one_src, long_src, short_src;

    // window as seen with the staged word already appended
    assign vwin_o[i] = (ctrl_i.push && fill_i == FILL_W'(i)) ? word_i : win_q[i];

    // shift sources, held in place where the shift runs off the end
    if (i + 1 < WINDOW_DEPTH) begin : g_s1
      assign one_src = vwin_o[i+1];
    end else begin : g_s1n
      assign one_src = vwin_o[i];
    end
    if (i + LEN_LONG < WINDOW_DEPTH) begin : g_sl
      assign long_src = vwin_o[i+LEN_LONG];
    end else begin : g_sln
      assign long_src = vwin_o[i];
    end
    if (i + LEN_SHORT < WINDOW_DEPTH) begin : g_ss
      assign short_src = vwin_o[i+LEN_SHORT];
    end else begin : g_ssn
      assign short_src = vwin_o[i];
    end

    // next entry value
    always_comb begin
      if (ctrl_i.shift_one) begin
        win_d[i] = one_src;
      end else if (ctrl_i.shift_pat) begin
        win_d[i] = (ctrl_i.sel == msb_pkg::SET_SHORT) ? short_src : long_src;
      end else begin
        win_d[i] = vwin_o[i];
      end
    end

    // payload storage, no reset
    always_ff @(posedge clk_i) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

@@ design/masked_sequence_blanker.sv @@
`timescale 1ns / 1ps
// masked_sequence_blanker: top level with input stage, step sequencer and result register
// depends on msb_pkg, msb_window, msb_match
//
// Words pass through a delay window as long as the selected pattern (27 or 12 words,
// capped at WINDOW_DEPTH) and come out in order; every word of a chunk matching the
// pattern comes out as zero, the chunk's first word flagged by chunk_start_o. An item
// that produces no more than one result does not hold the input register, so plain
// streams run at one word per cycle after the window fills, unless out_stall_i holds
// them. A matched chunk emits its L zeros through the single result register at one
// per cycle unless stalled, and the next word waits in the input register until they
// are out. A word with last_in_i drains the pending words likewise one per cycle,
// last_out_o marking the final result of that word; the same loop resolves surplus words
// left after a long-to-short switch. Write pattern_set only while the block is idle.
module masked_sequence_blanker #(
  parameter int unsigned WINDOW_DEPTH = 27
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           word_in_i,
  input  logic                  last_in_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           word_out_o,
  output logic                  chunk_start_o,
  output logic                  last_out_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  pattern_set_i
);

  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LEN_LONG  = msb_pkg::PAT_LEN[msb_pkg::SET_LONG];
  localparam int unsigned LEN_SHORT = msb_pkg::PAT_LEN[msb_pkg::SET_SHORT];
  localparam int unsigned LIM_LONG_I  = (LEN_LONG < WINDOW_DEPTH) ? LEN_LONG : WINDOW_DEPTH;
  localparam int unsigned LIM_SHORT_I = (LEN_SHORT < WINDOW_DEPTH) ? LEN_SHORT : WINDOW_DEPTH;
  localparam logic [FILL_W-1:0] LIM_LONG  = FILL_W'(LIM_LONG_I);
  localparam logic [FILL_W-1:0] LIM_SHORT = FILL_W'(LIM_SHORT_I);
  localparam logic [msb_pkg::ZRUN_W-1:0] ZRUN_LONG  = msb_pkg::ZRUN_W'(LEN_LONG - 1);
  localparam logic [msb_pkg::ZRUN_W-1:0] ZRUN_SHORT = msb_pkg::ZRUN_W'(LEN_SHORT - 1);

  // configuration
  logic sel_q;

  // input stage
  logic           in_vld_q;
  msb_pkg::word_t in_word_q;
  logic           in_last_q;

  // sequencer state
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [msb_pkg::ZRUN_W-1:0] zrun_q, zrun_d;
  logic                       act_q, act_d;
  logic                       drn_q, drn_d;
  logic                       zlast_q, zlast_d;

  // result register
  logic           out_vld_q;
  msb_pkg::word_t out_word_q;
  logic           out_start_q;
  logic           out_last_q;

  // step decode
  logic               out_ok, need_p, push, drain_v, live, iter, work, hit, more, match;
  logic [FILL_W-1:0]  fvp, fv, fnext, lim_sel;
  logic               emit, e_start, e_last;
  msb_pkg::word_t     e_word;
  msb_pkg::word_t     vwin [WINDOW_DEPTH];
  msb_pkg::win_ctrl_t wctrl;

  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= msb_pkg::SET_LONG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sel_q <= pattern_set_i;
    end
  end

  // input register, refilled in the cycle it is consumed
  assign in_stall_o = in_vld_q && !push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (push) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= word_in_i;
      in_last_q <= last_in_i;
    end
  end

  // push and loop iteration decode
  assign lim_sel = (sel_q == msb_pkg::SET_SHORT) ? LIM_SHORT : LIM_LONG;
  assign out_ok  = !out_vld_q || !out_stall_i;
  assign fvp     = fill_q + FILL_W'(1);
  assign need_p  = (fvp >= lim_sel) || in_last_q;
  assign push    = (zrun_q == '0) && !act_q && in_vld_q && (out_ok || !need_p);
  assign fv      = push ? fvp : fill_q;
  assign drain_v = push ? in_last_q : drn_q;
  assign live    = push || act_q;
  assign iter    = live && (fv >= lim_sel);
  assign work    = (zrun_q == '0) && live && (iter || drain_v) && out_ok;
  assign hit     = iter && match;
  assign fnext   = hit ? (fv - lim_sel) : (fv - FILL_W'(1));
  assign more    = (fnext >= lim_sel) || (drain_v && fnext != '0);

  // window and compare
  assign wctrl.push      = push;
  assign wctrl.shift_one = work && !hit;
  assign wctrl.shift_pat = work && hit;
  assign wctrl.sel       = sel_q;

  msb_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .ctrl_i (wctrl),
    .fill_i (fill_q),
    .word_i (in_word_q),
    .vwin_o (vwin)
  );

  msb_match #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_match (
    .sel_i   (sel_q),
    .win_i   (vwin),
    .match_o (match)
  );

  // sequencer next state and result selection
  always_comb begin
    emit    = 1'b0;
    e_word  = '0;
    e_start = 1'b0;
    e_last  = 1'b0;
    fill_d  = fill_q;
    zrun_d  = zrun_q;
    act_d   = act_q;
    drn_d   = drn_q;
    zlast_d = zlast_q;
    if (zrun_q != '0) begin
      // rest of a matched chunk
      if (out_ok) begin
        emit   = 1'b1;
        e_last = zlast_q && (zrun_q == msb_pkg::ZRUN_W'(1));
        zrun_d = zrun_q - msb_pkg::ZRUN_W'(1);
        if ((zrun_q == msb_pkg::ZRUN_W'(1)) && !act_q) begin
          drn_d = 1'b0;
        end
      end
    end else if (work) begin
      emit   = 1'b1;
      fill_d = fnext;
      act_d  = more;
      if (hit) begin
        e_start = 1'b1;
        zrun_d  = (sel_q == msb_pkg::SET_SHORT) ? ZRUN_SHORT : ZRUN_LONG;
        zlast_d = drain_v && !more;
        drn_d   = drain_v;
      end else begin
        e_word = vwin[0];
        e_last = drain_v && !more;
        drn_d  = drain_v && more;
      end
    end else if (push) begin
      fill_d = fv;
      act_d  = 1'b0;
      drn_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      zrun_q  <= '0;
      act_q   <= 1'b0;
      drn_q   <= 1'b0;
      zlast_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      zrun_q  <= zrun_d;
      act_q   <= act_d;
      drn_q   <= drn_d;
      zlast_q <= zlast_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ok) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q  <= e_word;
      out_start_q <= e_start;
      out_last_q  <= e_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign word_out_o    = out_word_q;
  assign chunk_start_o = out_start_q;
  assign last_out_o    = out_last_q;

  // window never stays full after a step
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_DEPTH - 1))
    else $error("window fill reached depth");

  // no new word enters while a chunk is still being emitted
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (zrun_q == '0) && !act_q)
    else $error("push during pending step");

  // a chunk start always carries a blanked word
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_start_o) |-> (word_out_o == '0))
    else $error("chunk start with nonzero word");

  // a match leaves the remaining zeros of the chunk pending
  a_match_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && hit) |=> (zrun_q != '0))
    else $error("match without pending zero run");

endmodule
